>>> hw/rtl/kmp_pattern_match_counter_top_defines.svh
// assertion macros used by the checker file
`ifndef KMP_PATTERN_MATCH_COUNTER_TOP_DEFINES_SVH
`define KMP_PATTERN_MATCH_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define KMPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define KMPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define KMPC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/kmpc_pkg.sv
`default_nettype none

package kmpc_pkg;

  // stored failure link meaning "no fallback"
  localparam logic [4:0] NO_LINK = 5'd31;

  // saturation limit of the match total
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd2;

  // one text byte as queued between front and back
  typedef struct packed {
    logic       last;
    logic       start;
    logic [7:0] char_val;
  } item_t;

  // pattern registers as seen by the back part
  typedef struct packed {
    logic [127:0] pattern;
    logic [4:0]   length;
  } pat_cfg_t;

  // byte i of the 16-byte pattern
  function automatic logic [7:0] pat_byte(input logic [127:0] p, input logic [3:0] i);
    return p[{i, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kmpc_front.sv
`default_nettype none

module kmpc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  // text byte stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              s_tuser,
  input  wire logic              s_tlast,
  // queue towards the back part
  output logic                   q_valid,
  output kmpc_pkg::item_t        q_item,
  input  wire logic              q_pop,
  output kmpc_pkg::pat_cfg_t     cfg
);

  logic [63:0]     pattern_low;
  logic [63:0]     pattern_high;
  logic [4:0]      pattern_length;
  kmpc_pkg::item_t q_mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      q_count;
  logic            push;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        kmpc_pkg::CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        kmpc_pkg::CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        kmpc_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = {pattern_high, pattern_low};
  assign cfg.length  = pattern_length;

  // two-entry queue of accepted bytes
  assign s_tready = (q_count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (q_count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{last: s_tlast, start: s_tuser, char_val: s_tdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kmpc_back.sv
`default_nettype none

module kmpc_back #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire kmpc_pkg::item_t   q_item,
  output logic                   q_pop,
  input  wire kmpc_pkg::pat_cfg_t cfg,
  // result stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int DEPTH = MAX_PATTERN + 1;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BUILD = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]   state;
  logic [127:0] pat;
  logic [4:0]   len;
  logic [4:0]   pos;
  logic [4:0]   bj;
  logic [4:0]   bk;
  logic [7:0]   char_val;
  logic         last;
  logic [4:0]   border;
  logic [15:0]  count;
  logic [15:0]  count_next;
  logic [4:0]   link_tab [DEPTH];

  logic [4:0]   len_clamp;
  logic [4:0]   tab_addr;
  logic [4:0]   rd;
  logic [7:0]   pj;
  logic [7:0]   pk;
  logic [7:0]   pj1;
  logic [7:0]   pk1;
  logic         bcond;
  logic [4:0]   bj1;
  logic [4:0]   bk1;
  logic [4:0]   wval;
  logic [4:0]   bk_fall;
  logic         tab_we;
  logic [7:0]   pc;
  logic         adv;
  logic [4:0]   wj1;
  logic [4:0]   fall;
  logic         hit;
  logic [4:0]   end_pos;
  logic         can_load;
  logic         load;

  // length clamped to the supported range
  always_comb begin
    if (cfg.length == 5'd0) begin
      len_clamp = 5'd1;
    end else if (cfg.length > 5'(MAX_PATTERN)) begin
      len_clamp = 5'(MAX_PATTERN);
    end else begin
      len_clamp = cfg.length;
    end
  end

  // table build step
  assign pj      = kmpc_pkg::pat_byte(pat, bj[3:0]);
  assign pk      = kmpc_pkg::pat_byte(pat, bk[3:0]);
  assign bcond   = (bk == kmpc_pkg::NO_LINK) || (pj == pk);
  assign bj1     = bj + 5'd1;
  assign bk1     = bk + 5'd1;
  assign pj1     = kmpc_pkg::pat_byte(pat, bj1[3:0]);
  assign pk1     = kmpc_pkg::pat_byte(pat, bk1[3:0]);
  assign wval    = ((bj1 < len) && (pj1 == pk1)) ? rd : bk1;
  assign bk_fall = (rd >= bk) ? kmpc_pkg::NO_LINK : rd;
  assign tab_we  = (state == S_BUILD) && (bj < len) && bcond;

  // single table read port, shared by build and walk
  assign tab_addr = (state == S_BUILD) ? (bcond ? bk1 : bk) : pos;
  assign rd = (tab_addr < 5'(DEPTH)) ? link_tab[tab_addr[AW-1:0]] : kmpc_pkg::NO_LINK;

  // one walk step along the failure links
  assign pc       = kmpc_pkg::pat_byte(pat, pos[3:0]);
  assign adv      = (pos == kmpc_pkg::NO_LINK) || (char_val == pc);
  assign wj1      = pos + 5'd1;
  assign fall     = (rd >= pos) ? kmpc_pkg::NO_LINK : rd;
  assign hit      = (wj1 >= len);
  assign end_pos  = hit ? ((border >= len) ? 5'd0 : border) : wj1;
  assign can_load = !m_tvalid || m_tready;
  assign load     = (state == S_WALK) && adv && can_load;
  assign q_pop    = (state == S_IDLE) && q_valid;

  // saturating total
  assign count_next = (hit && (count != kmpc_pkg::COUNT_MAX)) ? count + 16'd1 : count;

  // failure table storage
  always_ff @(posedge clk) begin
    if (q_pop && q_item.start) begin
      link_tab[0] <= kmpc_pkg::NO_LINK;
    end else if (tab_we) begin
      link_tab[bj1[AW-1:0]] <= wval;
    end
  end

  // sequencer and match state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pat   <= '0;
      len   <= 5'd1;
      pos   <= 5'd0;
      count <= 16'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.start) begin
              pat   <= cfg.pattern;
              len   <= len_clamp;
              pos   <= 5'd0;
              state <= S_BUILD;
            end else begin
              pos   <= (pos >= len) ? 5'd0 : pos;
              state <= S_WALK;
            end
          end
        end
        S_BUILD: begin
          if (bj >= len) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (adv) begin
            if (can_load) begin
              pos   <= end_pos;
              count <= count_next;
              state <= S_IDLE;
            end
          end else begin
            pos <= fall;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // build indexes, current byte and border of the whole pattern
  always_ff @(posedge clk) begin
    if (q_pop) begin
      char_val <= q_item.char_val;
      last     <= q_item.last;
      if (q_item.start) begin
        bj <= 5'd0;
        bk <= kmpc_pkg::NO_LINK;
      end
    end else if (state == S_BUILD && bj < len) begin
      if (bcond) begin
        bj <= bj1;
        bk <= bk1;
        if (bj1 == len) border <= wval;
      end else begin
        bk <= bk_fall;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= count_next;
      m_tuser <= hit;
      m_tlast <= last;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kmp_pattern_match_counter_top.sv
`default_nettype none

// channel   dir  handshake             payload
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
// s_        in   s_tvalid/s_tready     tdata text_char, tuser text_start, tlast text_last
// m_        out  m_tvalid/m_tready     tdata match_total, tuser match_found, tlast text_done
//
// a text byte is popped in S_IDLE, then S_WALK follows failure links until it advances
// a text start byte first rebuilds the failure table in S_BUILD before the walk
// build and walk share the single failure table read port in the back part
// reset empties the queue and output register, no clearing pass is run
// a two-entry queue keeps input flowing while a result waits on m_tready

module kmp_pattern_match_counter_top #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] text_char
  input  wire logic        s_tuser,  // [0] text_start
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // [15:0] match_total
  output logic             m_tuser,  // [0] match_found
  output logic             m_tlast
);

  logic                q_valid;
  logic                q_pop;
  kmpc_pkg::item_t     q_item;
  kmpc_pkg::pat_cfg_t  cfg;

  // accept and queue
  kmpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg       (cfg)
  );

  // rebuild, walk and count
  kmpc_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cfg      (cfg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

>>> hw/rtl/kmpc_checker.sv
`default_nettype none

`include "kmp_pattern_match_counter_top_defines.svh"

module kmpc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_ready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // a reported match always shows a non-zero total
  `KMPC_ASSERT_IMP(a_found_total, m_tvalid && m_tuser, m_tdata != 16'd0, "match with zero total")

  // a stalled result keeps its payload
  `KMPC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // no result straight after reset
  `KMPC_ASSERT_RST(a_rst_empty, rst, !m_tvalid, "result valid after reset")

  // configuration never back-pressures
  `KMPC_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready, "configuration request stalled")

endmodule

bind kmp_pattern_match_counter_top kmpc_checker u_kmpc_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);

`default_nettype wire
